// ===== sv/sorted_squares_merge_defines.svh =====
// assertion macros for the sorted squares merge checker
// needs signals named clock and reset in the scope of each use
`ifndef SORTED_SQUARES_MERGE_DEFINES_SVH
`define SORTED_SQUARES_MERGE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSM_ASSERT_NOW(label, cond_a, cond_c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_c)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SSM_ASSERT_NEXT(label, cond_a, cond_c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_c)) \
      else $error(msg);

`endif

// ===== sv/ssm_pkg.sv =====
// shared types and constants of the sorted squares merge block
// no dependencies
package ssm_pkg;

   // default sizing of the element store and the element width
   localparam int MAX_ELEMENTS_DEF = 64;
   localparam int VALUE_BITS_DEF   = 16;

   // width of one square on the result channel
   localparam int SQUARE_BITS = 31;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_MERGE
   } state_type;

   // which merge sides still hold elements
   typedef struct packed {
      logic lo;
      logic hi;
   } avail_type;

endpackage

// ===== sv/ssm_ram.sv =====
// generic synchronous ram, one write port and two registered read ports
// no dependencies
module ssm_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   output logic [WIDTH-1:0]     rd_data_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [WIDTH-1:0]     rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== sv/ssm_select.sv =====
// merge decision: compares the low and high candidates and squares the winner
// depends on ssm_pkg
module ssm_select #(
   parameter int VALUE_BITS = ssm_pkg::VALUE_BITS_DEF
) (
   input  ssm_pkg::avail_type              avail,
   input  logic signed [VALUE_BITS-1:0]    lo_raw,
   input  logic signed [VALUE_BITS-1:0]    hi_raw,
   output logic                            take_lo,
   output logic [ssm_pkg::SQUARE_BITS-1:0] square
);

   import ssm_pkg::*;

   localparam int PROD_BITS = 2 * VALUE_BITS;

   logic [VALUE_BITS-1:0] lo_abs;
   logic [VALUE_BITS-1:0] hi_abs;
   logic [PROD_BITS-1:0]  lo_prod;
   logic [PROD_BITS-1:0]  hi_prod;
   logic                  lo_smaller;

   // magnitudes; the most negative value still fits unsigned
   assign lo_abs = lo_raw[VALUE_BITS-1] ? (~lo_raw + VALUE_BITS'(1)) : lo_raw;
   assign hi_abs = hi_raw[VALUE_BITS-1] ? (~hi_raw + VALUE_BITS'(1)) : hi_raw;

   // low side by magnitude against high side as signed
   assign lo_smaller = !hi_raw[VALUE_BITS-1] && (lo_abs < hi_abs);

   // once one side runs dry the other keeps going
   assign take_lo = avail.lo && (!avail.hi || lo_smaller);

   // both squares in parallel, then pick
   assign lo_prod = PROD_BITS'(lo_abs) * PROD_BITS'(lo_abs);
   assign hi_prod = PROD_BITS'(hi_abs) * PROD_BITS'(hi_abs);
   assign square  = take_lo ? SQUARE_BITS'(lo_prod) : SQUARE_BITS'(hi_prod);

endmodule

// ===== sv/sorted_squares_merge.sv =====
// top level of the sorted squares merge block
// depends on ssm_pkg, ssm_ram and ssm_select
//
// Loads a run of signed values (ascending) one per cycle while busy is low: a
// transaction is taken on each clock with start high and busy low, and the
// one with req_is_last set closes the run. Values past MAX_ELEMENTS are
// dropped, but the last flag still closes the run. Leading negatives set the
// split point. After the last transaction busy rises while the block primes
// the element memory's two read ports, then gives one square per stored
// element, one per cycle in ascending order from the two-pointer merge,
// each on rsp_square for a single cycle with rsp_strobe high and the final
// one flagged by rsp_end_of_run. Results cannot be held off, so the
// receiver must take every strobe. The merge rate is set by the registered
// read of the element memory, fed back to its read address each cycle.
module sorted_squares_merge #(
   parameter int MAX_ELEMENTS = ssm_pkg::MAX_ELEMENTS_DEF,
   parameter int VALUE_BITS   = ssm_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [VALUE_BITS-1:0]    req_value,
   input  logic                            req_is_last,
   output logic                            rsp_strobe,
   output logic [ssm_pkg::SQUARE_BITS-1:0] rsp_square,
   output logic                            rsp_end_of_run
);

   import ssm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] neg_ff,   neg_in;
   logic [CNT_W-1:0] lp_ff,    lp_in;
   logic [CNT_W-1:0] hp_ff,    hp_in;
   logic [CNT_W-1:0] emit_ff,  emit_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [SQUARE_BITS-1:0] rsp_square_ff, rsp_square_in;
   logic                   rsp_end_ff,    rsp_end_in;

   logic                   accept;
   logic                   last_emit;
   logic [CNT_W-1:0]       emit_next;
   logic                   wr_en;
   logic [ADDR_W-1:0]      rd_lo_addr;
   logic [ADDR_W-1:0]      rd_hi_addr;
   logic [VALUE_BITS-1:0]  lo_data;
   logic [VALUE_BITS-1:0]  hi_data;
   avail_type              avail;
   logic                   take_lo;
   logic [SQUARE_BITS-1:0] pick_square;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign emit_next = emit_ff + CNT_W'(1);
   assign last_emit = (emit_next == count_ff);

   // element store; read addresses follow the next pointers so the data
   // lines up with the registered pointers
   assign rd_lo_addr = ADDR_W'(lp_in - CNT_W'(1));
   assign rd_hi_addr = ADDR_W'(hp_in);

   ssm_ram #(
      .WIDTH     (VALUE_BITS),
      .DEPTH     (MAX_ELEMENTS),
      .ADDR_BITS (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (ADDR_W'(count_ff)),
      .wr_data   (req_value),
      .rd_addr_a (rd_lo_addr),
      .rd_data_a (lo_data),
      .rd_addr_b (rd_hi_addr),
      .rd_data_b (hi_data)
   );

   // merge decision and square
   assign avail.lo = (lp_ff != '0);
   assign avail.hi = (hp_ff < count_ff);

   ssm_select #(
      .VALUE_BITS (VALUE_BITS)
   ) u_select (
      .avail   (avail),
      .lo_raw  (lo_data),
      .hi_raw  (hi_data),
      .take_lo (take_lo),
      .square  (pick_square)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_is_last) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (last_emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // counters, pointers and result register
   always_comb begin
      count_in      = count_ff;
      neg_in        = neg_ff;
      lp_in         = lp_ff;
      hp_in         = hp_ff;
      emit_in       = emit_ff;
      wr_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_square_in = rsp_square_ff;
      rsp_end_in    = rsp_end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // store while there is room, extend the leading negatives
               if (count_ff < CNT_W'(MAX_ELEMENTS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (req_value[VALUE_BITS-1] && (neg_ff == count_ff)) begin
                     neg_in = neg_ff + CNT_W'(1);
                  end
               end
               // both pointers start at the split
               if (req_is_last) begin
                  lp_in   = neg_in;
                  hp_in   = neg_in;
                  emit_in = '0;
               end
            end
         end
         ST_PRIME: begin
            // read ports are loaded from the pointers this cycle
         end
         ST_MERGE: begin
            rsp_strobe_in = 1'b1;
            rsp_square_in = pick_square;
            rsp_end_in    = last_emit;
            emit_in       = emit_next;
            if (take_lo) begin
               lp_in = lp_ff - CNT_W'(1);
            end else begin
               hp_in = hp_ff + CNT_W'(1);
            end
            // run done, clear for the next one
            if (last_emit) begin
               count_in = '0;
               neg_in   = '0;
               lp_in    = '0;
               hp_in    = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         neg_ff        <= '0;
         lp_ff         <= '0;
         hp_ff         <= '0;
         emit_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         neg_ff        <= neg_in;
         lp_ff         <= lp_in;
         hp_ff         <= hp_in;
         emit_ff       <= emit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_square_ff <= rsp_square_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_square     = rsp_square_ff;
   assign rsp_end_of_run = rsp_end_ff;

endmodule

// ===== sv/ssm_checker.sv =====
// port-level checks on the sorted squares merge top level, bound in below
// depends on sorted_squares_merge_defines.svh and sorted_squares_merge
`include "sorted_squares_merge_defines.svh"

module ssm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_is_last,
   input logic rsp_strobe,
   input logic rsp_end_of_run
);

   // results other than the final one come out while the block is busy
   `SSM_ASSERT_NOW(a_mid_result_busy, rsp_strobe && !rsp_end_of_run, busy, "result outside merge")

   // a closing transaction starts the merge, busy with no result while priming
   `SSM_ASSERT_NEXT(a_last_starts_merge, start && !busy && req_is_last, busy && !rsp_strobe, "merge did not start")

   // a loading transaction produces nothing and leaves the block free
   `SSM_ASSERT_NEXT(a_load_quiet, start && !busy && !req_is_last, !busy && !rsp_strobe, "load produced a result")

   // nothing follows the end of a run
   `SSM_ASSERT_NEXT(a_end_stops, rsp_strobe && rsp_end_of_run, !rsp_strobe, "result after end of run")

endmodule

bind sorted_squares_merge ssm_checker u_ssm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_is_last    (req_is_last),
   .rsp_strobe     (rsp_strobe),
   .rsp_end_of_run (rsp_end_of_run)
);

// ===== bench/sorted_squares_merge_tb.sv =====
// self-checking bench for the sorted squares merge block
// depends on ssm_pkg and sorted_squares_merge; every square is predicted in the
// bench and checked in order: a directed table, a full store, then random runs
module sorted_squares_merge_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssm_pkg::*;

   localparam int MAX_ELEMENTS   = MAX_ELEMENTS_DEF;
   localparam int VALUE_BITS     = VALUE_BITS_DEF;
   localparam int IDLE_PERCENT   = 37;
   localparam int RANDOM_TARGET  = 20;
   localparam int STALL_LIMIT    = 4000;
   localparam int TAIL_CYCLES    = 20;
   localparam int REPORT_LIMIT   = 10;
   localparam int NUM_DIRECTED   = 25;

   typedef logic signed [VALUE_BITS-1:0] element_type;

   // one square as it should appear on the result channel
   typedef struct packed {
      logic [SQUARE_BITS-1:0] square;
      logic                   end_of_run;
   } square_result_type;

   // one row of the directed stimulus; known_square is valid when has_known is set
   typedef struct packed {
      element_type            value;
      logic                   is_last;
      logic                   has_known;
      logic [SQUARE_BITS-1:0] known_square;
   } directed_row_type;

   // mixes of values for the random runs
   typedef enum logic [1:0] {
      MIX_FULL,
      MIX_NARROW,
      MIX_NEGATIVE,
      MIX_POSITIVE
   } value_mix_type;

   // single-element runs carry their square; longer runs go through the predictor
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{16'sh8000,  1'b1, 1'b1, 31'd1073741824},
      '{16'sh7fff,  1'b1, 1'b1, 31'd1073676289},
      '{16'sd0,     1'b1, 1'b1, 31'd0},
      '{-16'sd1,    1'b1, 1'b1, 31'd1},
      // ordinary ascending run straddling zero
      '{-16'sd7,    1'b0, 1'b0, 31'd0},
      '{-16'sd3,    1'b0, 1'b0, 31'd0},
      '{-16'sd1,    1'b0, 1'b0, 31'd0},
      '{16'sd2,     1'b0, 1'b0, 31'd0},
      '{16'sd5,     1'b1, 1'b0, 31'd0},
      // negatives only: low side drains downward
      '{-16'sd9,    1'b0, 1'b0, 31'd0},
      '{-16'sd4,    1'b0, 1'b0, 31'd0},
      '{-16'sd2,    1'b1, 1'b0, 31'd0},
      // non-negatives only: high side drains upward
      '{16'sd0,     1'b0, 1'b0, 31'd0},
      '{16'sd4,     1'b0, 1'b0, 31'd0},
      '{16'sh7fff,  1'b1, 1'b0, 31'd0},
      // equal magnitudes on both sides
      '{-16'sd3,    1'b0, 1'b0, 31'd0},
      '{16'sd3,     1'b1, 1'b0, 31'd0},
      // unsorted: negatives after the split stay on the high side
      '{16'sd5,     1'b0, 1'b0, 31'd0},
      '{-16'sd6,    1'b0, 1'b0, 31'd0},
      '{16'sd3,     1'b0, 1'b0, 31'd0},
      '{-16'sd1,    1'b1, 1'b0, 31'd0},
      // extremes inside one run
      '{16'sh8000,  1'b0, 1'b0, 31'd0},
      '{-16'sd5,    1'b0, 1'b0, 31'd0},
      '{16'sd0,     1'b0, 1'b0, 31'd0},
      '{16'sh7fff,  1'b1, 1'b0, 31'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   element_type            req_value = '0;
   logic                   req_is_last = 1'b0;
   logic                   rsp_strobe;
   logic [SQUARE_BITS-1:0] rsp_square;
   logic                   rsp_end_of_run;

   // predictor state: the current run as the block holds it
   element_type       held_elements [MAX_ELEMENTS];
   int                held_count = 0;
   int                negative_run = 0;
   square_result_type expected_squares [$];

   int mismatch_count = 0;
   int stall_cycles   = 0;
   bit gaps_on        = 1'b1;

   sorted_squares_merge u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_is_last    (req_is_last),
      .rsp_strobe     (rsp_strobe),
      .rsp_square     (rsp_square),
      .rsp_end_of_run (rsp_end_of_run)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
   endfunction

   // append one predicted square to the expected queue
   function automatic void queue_square(input logic [SQUARE_BITS-1:0] square,
                                        input logic end_of_run);
      square_result_type entry;
      entry.square     = square;
      entry.end_of_run = end_of_run;
      expected_squares = {expected_squares, entry};
   endfunction

   // store one element and, on the last one, queue the merged squares
   task automatic fold_element(input element_type value, input logic is_last);
      int     lo_ptr;
      int     hi_ptr;
      int     total;
      int     produced;
      longint lo_mag;
      longint hi_val;
      longint mag;
      bit     take_low;
      if (held_count < MAX_ELEMENTS) begin
         if (value < 0 && negative_run == held_count) begin
            negative_run++;
         end
         held_elements[held_count] = value;
         held_count++;
      end
      if (is_last) begin
         total    = held_count;
         lo_ptr   = negative_run;
         hi_ptr   = negative_run;
         produced = 0;
         while (lo_ptr > 0 || hi_ptr < total) begin
            lo_mag = 0;
            hi_val = 0;
            if (lo_ptr > 0) begin
               lo_mag = longint'(held_elements[lo_ptr - 1]);
               if (lo_mag < 0) lo_mag = -lo_mag;
            end
            if (hi_ptr < total) begin
               hi_val = longint'(held_elements[hi_ptr]);
            end
            take_low = (lo_ptr > 0) && (hi_ptr >= total || lo_mag < hi_val);
            if (take_low) begin
               mag = lo_mag;
               lo_ptr--;
            end else begin
               mag = (hi_val < 0) ? -hi_val : hi_val;
               hi_ptr++;
            end
            produced++;
            queue_square(SQUARE_BITS'(mag * mag), (produced == total));
         end
         held_count   = 0;
         negative_run = 0;
      end
   endtask

   // offer one element, with random idle cycles ahead of it, until it is taken
   task automatic send_element(input element_type value, input logic is_last);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         start       <= 1'b0;
         req_value   <= element_type'($urandom);
         req_is_last <= 1'($urandom);
         @(posedge clock);
      end
      start       <= 1'b1;
      req_value   <= value;
      req_is_last <= is_last;
      do @(posedge clock); while (busy !== 1'b0);
      fold_element(value, is_last);
   endtask

   // hold the sender off until every queued square has come back
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_squares.size() != 0);
   endtask

   // result checker: each strobe is one transaction, compared in order
   always @(posedge clock) begin
      square_result_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_squares.size() == 0) begin
            note_mismatch($sformatf("unexpected square %0d end %b", rsp_square,
                                    rsp_end_of_run));
         end else begin
            want = expected_squares.pop_front();
            if (rsp_strobe !== 1'b1 || rsp_square !== want.square) begin
               note_mismatch($sformatf("square expected %0d got %0d (strobe %b)",
                                       want.square, rsp_square, rsp_strobe));
            end
            if (rsp_end_of_run !== want.end_of_run) begin
               note_mismatch($sformatf("end_of_run expected %b got %b",
                                       want.end_of_run, rsp_end_of_run));
            end
         end
      end
   end

   // watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", stall_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus
   initial begin
      int            random_items;
      int            run_index;
      int            run_len;
      int            pick;
      bit            sorted_run;
      value_mix_type mix;
      int            run_values [$];

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_element(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].is_last);
         if (DIRECTED_ROWS[i].has_known) begin
            expected_squares[expected_squares.size() - 1] =
               '{square: DIRECTED_ROWS[i].known_square, end_of_run: 1'b1};
         end
      end

      // full store, back to back: the last two values are dropped, the last
      // flag still merges
      drain_results();
      run_values.delete();
      for (int k = 0; k < MAX_ELEMENTS + 2; k++) begin
         run_values = {run_values, int'($urandom_range(65535)) - 32768};
      end
      run_values.sort();
      gaps_on = 1'b0;
      foreach (run_values[k]) begin
         send_element(element_type'(run_values[k]), k == run_values.size() - 1);
      end
      gaps_on = 1'b1;

      // random runs, mostly sorted and short, a few unsorted
      random_items = 0;
      run_index    = 0;
      while (random_items < RANDOM_TARGET) begin
         run_len    = ($urandom_range(7) == 0) ? $urandom_range(13, MAX_ELEMENTS)
                                               : $urandom_range(1, 12);
         if (run_len > RANDOM_TARGET - random_items) begin
            run_len = RANDOM_TARGET - random_items;
         end
         sorted_run = ($urandom_range(9) < 8);
         mix        = value_mix_type'($urandom_range(3));
         run_values.delete();
         for (int k = 0; k < run_len; k++) begin
            case (mix)
               MIX_FULL:     pick = int'($urandom_range(65535)) - 32768;
               MIX_NARROW:   pick = int'($urandom_range(40)) - 20;
               MIX_NEGATIVE: pick = -int'($urandom_range(1, 32768));
               default:      pick = int'($urandom_range(32767));
            endcase
            run_values = {run_values, pick};
         end
         if (sorted_run) run_values.sort();

         // one more full drain between runs
         if (run_index == 1) drain_results();

         foreach (run_values[k]) begin
            send_element(element_type'(run_values[k]), k == run_len - 1);
         end
         random_items += run_len;
         run_index++;
      end

      // wait out the last merge, then a short tail for stray strobes
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
